// ----- design/spq_pkg.sv -----
// Shared types and constants for the stable priority queue.
package spq_pkg;

  localparam int CAPACITY     = 16;
  localparam int PAYLOAD_BITS = 16;
  localparam int PRIO_BITS    = 8;
  localparam int CNT_W        = $clog2(CAPACITY + 1);

  typedef enum logic {
    REQ_ENQ = 1'b0,
    REQ_DEQ = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_SERVED   = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_ENQ  = 2'd1,
    OP_DEQ  = 2'd2
  } op_e;

  typedef struct packed {
    req_e        req_type;
    logic [15:0] payload;
    logic [7:0]  prio;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] served_payload;
    logic [7:0]  served_prio;
    logic        is_empty;
    logic [4:0]  occupancy;
  } out_t;

  typedef struct packed {
    op_e     op;
    logic    load;
    status_e status;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } sts_t;

endpackage

// ----- design/spq_datapath.sv -----
// Sorted row of shift-insert cells, entry count and result register.
module spq_datapath import spq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  in_t  item_i,
  output sts_t sts_o,
  output out_t res_o
);

  logic [PAYLOAD_BITS-1:0] pay_q  [CAPACITY];
  logic [PAYLOAD_BITS-1:0] pay_d  [CAPACITY];
  logic [PRIO_BITS-1:0]    prio_q [CAPACITY];
  logic [PRIO_BITS-1:0]    prio_d [CAPACITY];
  logic [CAPACITY-1:0]     ge;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [PAYLOAD_BITS-1:0] new_pay;
  logic [PRIO_BITS-1:0]    new_prio;
  out_t                    res_q, res_d;

  assign new_pay  = PAYLOAD_BITS'(item_i.payload);
  assign new_prio = PRIO_BITS'(item_i.prio);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign ge[i] = (CNT_W'(i) < count_q) && (prio_q[i] >= new_prio);

    always_comb begin
      pay_d[i]  = pay_q[i];
      prio_d[i] = prio_q[i];
      case (cmd_i.op)
        OP_ENQ: begin
          if (!ge[i]) begin
            if (i == 0) begin
              pay_d[i]  = new_pay;
              prio_d[i] = new_prio;
            end else if (ge[(i == 0) ? 0 : i-1]) begin
              pay_d[i]  = new_pay;
              prio_d[i] = new_prio;
            end else begin
              pay_d[i]  = pay_q[(i == 0) ? 0 : i-1];
              prio_d[i] = prio_q[(i == 0) ? 0 : i-1];
            end
          end
        end
        OP_DEQ: begin
          if (i < CAPACITY - 1) begin
            pay_d[i]  = pay_q[(i < CAPACITY - 1) ? i+1 : i];
            prio_d[i] = prio_q[(i < CAPACITY - 1) ? i+1 : i];
          end
        end
        default: ;
      endcase
    end

    always_ff @(posedge clk_i) begin
      pay_q[i]  <= pay_d[i];
      prio_q[i] <= prio_d[i];
    end
  end

  always_comb begin
    count_d = count_q;
    case (cmd_i.op)
      OP_ENQ:  count_d = count_q + CNT_W'(1);
      OP_DEQ:  count_d = count_q - CNT_W'(1);
      default: ;
    endcase
  end

  always_comb begin
    res_d                = res_q;
    if (cmd_i.load) begin
      res_d.status         = cmd_i.status;
      res_d.served_payload = '0;
      res_d.served_prio    = '0;
      if (cmd_i.op == OP_DEQ) begin
        res_d.served_payload = 16'(pay_q[0]);
        res_d.served_prio    = 8'(prio_q[0]);
      end
      res_d.is_empty  = (count_d == '0);
      res_d.occupancy = 5'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign sts_o.full  = (count_q == CNT_W'(CAPACITY));
  assign sts_o.empty = (count_q == '0);
  assign res_o       = res_q;

endmodule

// ----- design/spq_ctrl.sv -----
// Handshake controller: decodes each request and tracks the held result.
module spq_ctrl import spq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  req_e req_type_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_HOLD
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o  = (state_q == S_IDLE) || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == S_HOLD);

  always_comb begin
    cmd_o.op     = OP_NONE;
    cmd_o.load   = accept;
    cmd_o.status = ST_ENQUEUED;
    case (req_type_i)
      REQ_ENQ: begin
        if (sts_i.full) begin
          cmd_o.status = ST_FULL;
        end else begin
          cmd_o.status = ST_ENQUEUED;
          cmd_o.op     = accept ? OP_ENQ : OP_NONE;
        end
      end
      REQ_DEQ: begin
        if (sts_i.empty) begin
          cmd_o.status = ST_EMPTY;
        end else begin
          cmd_o.status = ST_SERVED;
          cmd_o.op     = accept ? OP_DEQ : OP_NONE;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    if (accept) begin
      state_d = S_HOLD;
    end else if (out_ready_i) begin
      state_d = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- design/stable_priority_queue.sv -----
// Stable bounded priority queue: one request in, one result item out.
// For each accepted item, all cells compare the new priority in parallel
// and shift to insert, or shift toward the head on a dequeue; the result
// is registered and shows in the cycle after acceptance. A new item is
// taken every cycle while the result is drained, so sustained throughput
// is one item per cycle while the output is ready. Higher priority
// leaves first, equal priorities leave in arrival order; an enqueue to a full
// queue returns the full status and a dequeue on an empty queue the empty
// status, both leaving the contents unchanged.
module stable_priority_queue import spq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_item_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_item_o
);

  cmd_t cmd;
  sts_t sts;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .req_type_i  (in_item_i.req_type),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  spq_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .item_i (in_item_i),
    .sts_o  (sts),
    .res_o  (out_item_o)
  );

endmodule

// ----- tb/sv/stable_priority_queue_tb.sv -----
// Self-checking testbench for the stable priority queue: random and directed items vs. a shadow queue.
module stable_priority_queue_tb;
  import spq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_LIMIT  = 1000;
  localparam int RANDOM_ITEMS = 1400;

  class spq_order_check;
    logic [PAYLOAD_BITS-1:0] shadow_tag [CAPACITY];
    logic [PRIO_BITS-1:0]    shadow_rank [CAPACITY];
    int unsigned shadow_count;
    out_t        due_results [$];
    int unsigned errors;
    int unsigned n_requests, n_enqueued, n_served, n_on_empty, n_rejected, peak_count;

    function new();
      shadow_count = 0;
      errors       = 0;
      n_requests   = 0;
      n_enqueued   = 0;
      n_served     = 0;
      n_on_empty   = 0;
      n_rejected   = 0;
      peak_count   = 0;
    endfunction

    function void note_request(in_t req);
      out_t                    res;
      int unsigned             pos;
      int unsigned             i;
      logic [PAYLOAD_BITS-1:0] tag;
      logic [PRIO_BITS-1:0]    rank;
      res  = '0;
      tag  = req.payload[PAYLOAD_BITS-1:0];
      rank = req.prio[PRIO_BITS-1:0];
      n_requests++;
      if (req.req_type == REQ_ENQ) begin
        if (shadow_count >= CAPACITY) begin
          res.status = ST_FULL;
          n_rejected++;
        end else begin
          pos = 0;
          while (pos < shadow_count && shadow_rank[pos] >= rank) pos++;
          for (i = shadow_count; i > pos; i--) begin
            shadow_tag[i]  = shadow_tag[i-1];
            shadow_rank[i] = shadow_rank[i-1];
          end
          shadow_tag[pos]  = tag;
          shadow_rank[pos] = rank;
          shadow_count++;
          res.status = ST_ENQUEUED;
          n_enqueued++;
        end
      end else if (shadow_count == 0) begin
        res.status = ST_EMPTY;
        n_on_empty++;
      end else begin
        res.status         = ST_SERVED;
        res.served_payload = 16'(shadow_tag[0]);
        res.served_prio    = 8'(shadow_rank[0]);
        for (i = 1; i < shadow_count; i++) begin
          shadow_tag[i-1]  = shadow_tag[i];
          shadow_rank[i-1] = shadow_rank[i];
        end
        shadow_count--;
        n_served++;
      end
      if (shadow_count > peak_count) peak_count = shadow_count;
      res.is_empty  = (shadow_count == 0);
      res.occupancy = 5'(shadow_count);
      due_results.push_back(res);
    endfunction

    function void check_result(out_t got);
      out_t  want;
      string bad;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected result item status=%0d payload=%h prio=%h", $realtime,
                   got.status, got.served_payload, got.served_prio);
        return;
      end
      want = due_results.pop_front();
      bad  = "";
      if (got.status !== want.status) bad = {bad, " status"};
      if (got.served_payload !== want.served_payload) bad = {bad, " served_payload"};
      if (got.served_prio !== want.served_prio) bad = {bad, " served_prio"};
      if (got.is_empty !== want.is_empty) bad = {bad, " is_empty"};
      if (got.occupancy !== want.occupancy) bad = {bad, " occupancy"};
      if (bad != "") begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch on%s: exp st=%0d pay=%h pri=%h emp=%b occ=%0d, got st=%0d pay=%h pri=%h emp=%b occ=%0d",
                   $realtime, bad, want.status, want.served_payload, want.served_prio,
                   want.is_empty, want.occupancy, got.status, got.served_payload,
                   got.served_prio, got.is_empty, got.occupancy);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  in_t  in_item_i   = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_item_o;

  spq_order_check order_check = new();
  int unsigned    burst_left  = 0;
  int unsigned    rx_phase    = 0;
  logic [1:0]     rx_mode     = 2'd0;

  stable_priority_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) order_check.note_request(in_item_i);
    if (out_valid_o && out_ready_i) order_check.check_result(out_item_o);
  end

  always @(posedge clk_i) begin
    if (rx_phase == 0) begin
      rx_mode  <= 2'($urandom_range(0, 3));
      rx_phase <= $urandom_range(20, 80);
    end else begin
      rx_phase <= rx_phase - 1;
    end
    case (rx_mode)
      2'd0: out_ready_i <= 1'b1;
      2'd1: out_ready_i <= 1'($urandom_range(0, 1));
      2'd2: out_ready_i <= ($urandom_range(0, 7) == 0);
      default: out_ready_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    wait (rst_ni);
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
    $display("stable_priority_queue_tb: done, errors");
    $finish;
  end

  function automatic in_t make_req(req_e kind, logic [15:0] tag, logic [7:0] rank);
    in_t req;
    req.req_type = kind;
    req.payload  = tag;
    req.prio     = rank;
    return req;
  endfunction

  task automatic push_request(input in_t req);
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_item_i  <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end else begin
      burst_left--;
    end
  endtask

  initial begin
    in_t         req;
    int unsigned enq_pct;
    int unsigned rank_mode;
    int unsigned phase_left;
    int unsigned drain;
    logic [7:0]  corner_ranks [4];

    corner_ranks = '{8'd0, 8'd255, 8'd127, 8'd128};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_request(make_req(REQ_DEQ, 16'hFFFF, 8'hFF));
    push_request(make_req(REQ_ENQ, 16'h0000, 8'd0));
    push_request(make_req(REQ_ENQ, 16'hFFFF, 8'd255));
    push_request(make_req(REQ_ENQ, 16'h0001, 8'd255));
    push_request(make_req(REQ_ENQ, 16'h0002, 8'd0));
    push_request(make_req(REQ_ENQ, 16'h1234, 8'd128));
    push_request(make_req(REQ_ENQ, 16'h00AA, 8'd128));
    push_request(make_req(REQ_ENQ, 16'h5555, 8'd1));
    push_request(make_req(REQ_ENQ, 16'hAAAA, 8'd254));
    for (int i = 0; i < 8; i++) push_request(make_req(REQ_ENQ, 16'h0100 + 16'(i), 8'd128));
    push_request(make_req(REQ_ENQ, 16'hBEEF, 8'd255));
    repeat (4) push_request(make_req(REQ_DEQ, 16'h5A5A, 8'hA5));

    phase_left = 0;
    enq_pct    = 50;
    rank_mode  = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        case ($urandom_range(0, 2))
          0: enq_pct = 15;
          1: enq_pct = 50;
          default: enq_pct = 85;
        endcase
        rank_mode  = $urandom_range(0, 2);
        phase_left = $urandom_range(30, 60);
      end
      phase_left--;
      req.req_type = ($urandom_range(0, 99) < enq_pct) ? REQ_ENQ : REQ_DEQ;
      req.payload  = 16'($urandom);
      case (rank_mode)
        0: req.prio = 8'($urandom);
        1: req.prio = 8'($urandom_range(0, 3));
        default: req.prio = corner_ranks[$urandom_range(0, 3)];
      endcase
      push_request(req);
    end
    in_valid_i <= 1'b0;

    drain = 0;
    while (order_check.due_results.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (4) @(posedge clk_i);
    if (order_check.due_results.size() != 0) begin
      order_check.errors++;
      $display("%0d expected result items never arrived", order_check.due_results.size());
    end

    $display("covered %0d requests: %0d enqueued, %0d served, %0d rejected as full, %0d on empty",
             order_check.n_requests, order_check.n_enqueued, order_check.n_served,
             order_check.n_rejected, order_check.n_on_empty);
    $display("peak occupancy %0d of %0d, %0d mismatches", order_check.peak_count, CAPACITY,
             order_check.errors);
    if (order_check.errors == 0) begin
      $display("stable_priority_queue_tb: done, clean");
    end else begin
      $display("stable_priority_queue_tb: done, errors");
    end
    $finish;
  end

endmodule
